FILE: hw/rtl/ncm_pkg.sv
// Shared types, widths, codes and constants of the NTSC chroma modulator.
package ncm_pkg;

	// Fixed field widths.
	localparam int LUMA_W      = 14;
	localparam int CHROMA_W    = 14;
	localparam int PHASE_W     = 2;
	localparam int LEVEL_W     = 17;
	localparam int GAIN_W      = 16;
	localparam int SAMPLE_W    = 16;
	localparam int STEPS_W     = 4;
	localparam int CFG_IDX_W   = 2;
	localparam int CFG_DATA_W  = 17;
	// Clamped luma is never above 8191, so 13 unsigned bits hold it.
	localparam int Y_W         = 13;
	// Holds a scaling count of up to sixteen.
	localparam int STEP_CNT_W  = 5;

	// Parameter defaults.
	localparam int DEF_MAX_GAMUT_STEPS = 8;
	localparam int DEF_COLOR_FRAC_BITS = 12;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] CFG_BLACK = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_WHITE = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_SYNC  = 2'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_GAIN  = 2'd3;

	// Quadrature phase codes: the component that the subcarrier carries.
	localparam logic [PHASE_W-1:0] PH_I     = 2'd0;
	localparam logic [PHASE_W-1:0] PH_Q     = 2'd1;
	localparam logic [PHASE_W-1:0] PH_NEG_I = 2'd2;
	localparam logic [PHASE_W-1:0] PH_NEG_Q = 2'd3;

	// Register values after reset.
	localparam logic signed [LEVEL_W-1:0] RST_BLACK = 17'sd1920;
	localparam logic signed [LEVEL_W-1:0] RST_WHITE = 17'sd25600;
	localparam logic signed [LEVEL_W-1:0] RST_SYNC  = -17'sd10240;
	localparam logic [GAIN_W-1:0]         RST_GAIN  = 16'd5120;

	// YIQ to RGB coefficients, scaled by 10000.
	localparam int UNIT_SCALE = 10000;
	localparam int COEF_RI    = 9563;
	localparam int COEF_RQ    = 6210;
	localparam int COEF_GI    = 2721;
	localparam int COEF_GQ    = 6474;
	localparam int COEF_BI    = 11070;
	localparam int COEF_BQ    = 17046;

	// Division by ten as a multiply by ceil(2^19 / 10) and a shift; exact for
	// dividends well beyond the largest 9*|x|+5 that occurs.
	localparam int RECIP_TEN   = 52429;
	localparam int RECIP_SHIFT = 19;

	// Output levels in IRE times 256.
	localparam int WHITE_CLIP = 30720;
	localparam int OUT_MIN    = -20480;
	localparam int OUT_MAX    = 35840;
	localparam int SAT_MAX    = 32767;

	// One sample as it moves along the gamut chain.
	typedef struct packed {
		logic                       done;
		logic [STEP_CNT_W-1:0]      steps;
		logic [PHASE_W-1:0]         phase;
		logic [Y_W-1:0]             y;
		logic signed [CHROMA_W-1:0] ci;
		logic signed [CHROMA_W-1:0] cq;
	} ncm_item_t;

endpackage

FILE: hw/rtl/ncm_gamut_cell.sv
// One gamut limiting cell: tests RGB range and applies at most one 0.9 chroma scaling.
module ncm_gamut_cell #(
	parameter int COLOR_FRAC_BITS = ncm_pkg::DEF_COLOR_FRAC_BITS
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               adv,
	input  logic               valid_in,
	input  ncm_pkg::ncm_item_t item_in,
	output logic               valid_out,
	output ncm_pkg::ncm_item_t item_out
);

	localparam int GW = (COLOR_FRAC_BITS + 16 > 31) ? COLOR_FRAC_BITS + 16 : 31;
	localparam int PW = 33;
	localparam int MW = ncm_pkg::CHROMA_W + 3;
	localparam logic signed [GW-1:0] UNIT_Q =
		GW'(longint'(ncm_pkg::UNIT_SCALE) <<< COLOR_FRAC_BITS);

	// (9*|x| + 5) times the reciprocal of ten, before the shift.
	function automatic logic [PW-1:0] scale_prod(input logic signed [ncm_pkg::CHROMA_W-1:0] x);
		logic [ncm_pkg::CHROMA_W-1:0] mag;
		logic [MW-1:0]                t;
		mag = x[ncm_pkg::CHROMA_W-1] ? ncm_pkg::CHROMA_W'(-x) : ncm_pkg::CHROMA_W'(x);
		t   = MW'(mag) * MW'(9) + MW'(5);
		return PW'(t) * PW'(ncm_pkg::RECIP_TEN);
	endfunction

	logic               valid_s1;
	ncm_pkg::ncm_item_t item_s1;
	logic signed [GW-1:0] y10k_s1, ri_s1, rq_s1, gi_s1, gq_s1, bi_s1, bq_s1;
	logic [PW-1:0]      pi_s1, pq_s1;

	logic               valid_s2;
	ncm_pkg::ncm_item_t item_s2;

	logic signed [GW-1:0] r_sum, g_sum, b_sum;
	logic                 in_gamut;
	logic [ncm_pkg::CHROMA_W-1:0] qi, qq;
	logic signed [ncm_pkg::CHROMA_W-1:0] si, sq;
	ncm_pkg::ncm_item_t   item_nx;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else if (adv) begin
			valid_s1 <= valid_in;
			valid_s2 <= valid_s1;
		end
	end

	// First stage: all constant products in parallel.
	always_ff @(posedge clk) begin
		if (adv) begin
			item_s1 <= item_in;
			y10k_s1 <= GW'(ncm_pkg::UNIT_SCALE * int'(item_in.y));
			ri_s1   <= GW'(ncm_pkg::COEF_RI * item_in.ci);
			rq_s1   <= GW'(ncm_pkg::COEF_RQ * item_in.cq);
			gi_s1   <= GW'(ncm_pkg::COEF_GI * item_in.ci);
			gq_s1   <= GW'(ncm_pkg::COEF_GQ * item_in.cq);
			bi_s1   <= GW'(ncm_pkg::COEF_BI * item_in.ci);
			bq_s1   <= GW'(ncm_pkg::COEF_BQ * item_in.cq);
			pi_s1   <= scale_prod(item_in.ci);
			pq_s1   <= scale_prod(item_in.cq);
		end
	end

	// Second stage: range test, rounded scaling and selection.
	always_comb begin
		r_sum    = y10k_s1 + ri_s1 + rq_s1;
		g_sum    = y10k_s1 - gi_s1 - gq_s1;
		b_sum    = y10k_s1 - bi_s1 + bq_s1;
		in_gamut = (r_sum >= 0) && (r_sum <= UNIT_Q) &&
		           (g_sum >= 0) && (g_sum <= UNIT_Q) &&
		           (b_sum >= 0) && (b_sum <= UNIT_Q);
		qi = ncm_pkg::CHROMA_W'(pi_s1 >> ncm_pkg::RECIP_SHIFT);
		qq = ncm_pkg::CHROMA_W'(pq_s1 >> ncm_pkg::RECIP_SHIFT);
		si = item_s1.ci[ncm_pkg::CHROMA_W-1] ? -$signed(qi) : $signed(qi);
		sq = item_s1.cq[ncm_pkg::CHROMA_W-1] ? -$signed(qq) : $signed(qq);
		item_nx = item_s1;
		if (!item_s1.done) begin
			if (in_gamut) begin
				item_nx.done = 1'b1;
			end else begin
				item_nx.ci    = si;
				item_nx.cq    = sq;
				item_nx.steps = item_s1.steps + ncm_pkg::STEP_CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			item_s2 <= item_nx;
		end
	end

	assign valid_out = valid_s2;
	assign item_out  = item_s2;

endmodule

FILE: hw/rtl/ncm_level.sv
// Output stage: subcarrier phase selection, level sum, clamps and rounding.
module ncm_level #(
	parameter int COLOR_FRAC_BITS = ncm_pkg::DEF_COLOR_FRAC_BITS
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  adv,
	input  logic                                  valid_in,
	input  ncm_pkg::ncm_item_t                    item_in,
	input  logic signed [ncm_pkg::LEVEL_W-1:0]    black_level,
	input  logic signed [ncm_pkg::LEVEL_W-1:0]    white_level,
	input  logic signed [ncm_pkg::LEVEL_W-1:0]    sync_level,
	input  logic [ncm_pkg::GAIN_W-1:0]            carrier_gain,
	output logic                                  valid_out,
	output logic signed [ncm_pkg::SAMPLE_W-1:0]   composite,
	output logic [ncm_pkg::STEPS_W-1:0]           steps
);

	localparam int F  = COLOR_FRAC_BITS;
	localparam int VW = (F + 20 > 33) ? F + 20 : 33;
	localparam int QW = VW - F;
	localparam int MODW = ncm_pkg::CHROMA_W + 1;
	localparam logic signed [VW-1:0] HI_Q = VW'(longint'(ncm_pkg::WHITE_CLIP) <<< F);
	localparam logic [F-1:0]         HALF = F'(1) << (F - 1);
	localparam logic signed [QW-1:0] RES_MIN = QW'(ncm_pkg::OUT_MIN);
	localparam logic signed [QW-1:0] RES_MAX = QW'(ncm_pkg::OUT_MAX);
	localparam logic signed [QW-1:0] RES_SAT = QW'(ncm_pkg::SAT_MAX);

	logic signed [ncm_pkg::LEVEL_W:0] diff_q;
	logic signed [MODW-1:0]           mod;

	logic                             valid_s1, valid_s2, valid_s3;
	logic signed [31:0]               prod_y_s1, prod_c_s1;
	logic [ncm_pkg::STEP_CNT_W-1:0]   steps_s1, steps_s2;
	logic [ncm_pkg::STEPS_W-1:0]      steps_s3;
	logic signed [VW-1:0]             v_s2;
	logic signed [ncm_pkg::SAMPLE_W-1:0] comp_s3;

	logic signed [VW-1:0]             lvl, lo_q;
	logic signed [QW-1:0]             rq, res;
	logic [F-1:0]                     rem;

	always_comb begin
		unique case (item_in.phase)
			ncm_pkg::PH_I:     mod = MODW'(item_in.ci);
			ncm_pkg::PH_Q:     mod = MODW'(item_in.cq);
			ncm_pkg::PH_NEG_I: mod = -MODW'(item_in.ci);
			ncm_pkg::PH_NEG_Q: mod = -MODW'(item_in.cq);
			default:           mod = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else if (adv) begin
			valid_s1 <= valid_in;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
		end
	end

	// Levels must change only while idle, which the block does not enforce; this tracks them freely.
	always_ff @(posedge clk) begin
		diff_q <= (ncm_pkg::LEVEL_W + 1)'(white_level) - (ncm_pkg::LEVEL_W + 1)'(black_level);
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			prod_y_s1 <= 32'($signed({1'b0, item_in.y})) * 32'(diff_q);
			prod_c_s1 <= 32'($signed({1'b0, carrier_gain})) * 32'(mod);
			steps_s1  <= item_in.steps;
		end
	end

	// Sum, then the white clip, then the sync floor which wins a conflict.
	always_comb begin
		lo_q = VW'(sync_level) <<< F;
		lvl  = (VW'(black_level) <<< F) + VW'(prod_y_s1) + VW'(prod_c_s1);
		if (lvl > HI_Q) begin
			lvl = HI_Q;
		end
		if (lvl < lo_q) begin
			lvl = lo_q;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			v_s2     <= lvl;
			steps_s2 <= steps_s1;
		end
	end

	// Round to nearest with ties to even, then the output range limits.
	always_comb begin
		rq  = QW'(v_s2 >>> F);
		rem = v_s2[F-1:0];
		res = rq;
		if ((rem > HALF) || ((rem == HALF) && rq[0])) begin
			res = rq + QW'(1);
		end
		if (res < RES_MIN) begin
			res = RES_MIN;
		end
		if (res > RES_MAX) begin
			res = RES_MAX;
		end
		if (res > RES_SAT) begin
			res = RES_SAT;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			comp_s3  <= ncm_pkg::SAMPLE_W'(res);
			steps_s3 <= ncm_pkg::STEPS_W'(steps_s2);
		end
	end

	assign valid_out = valid_s3;
	assign composite = comp_s3;
	assign steps     = steps_s3;

endmodule

FILE: hw/rtl/ntsc_chroma_modulator.sv
// Top level of the NTSC chroma modulator: registers, gamut cell chain, output stage.
//
// Channel   Handshake                    Payload
// sample    sample_valid / sample_stall  luma, chroma_i, chroma_q, frame_phase, line_odd, sample_phase
// result    result_valid / result_stall  composite_sample, gamut_steps
// config    cfg_we                       cfg_index, cfg_wdata
//
// One sample is taken per clock and one result leaves per clock, unless a stalled
// result holds the pipeline. Between a sample transfer and its result lie one entry
// register, two stages in each gamut cell of the chain, and three in the output stage.
// Reset clears every valid bit and loads the register defaults; there is no
// clearing pass. A stalled result freezes the whole pipeline, and sample_stall
// is raised in that same cycle, so nothing is lost or overwritten.
module ntsc_chroma_modulator #(
	parameter int MAX_GAMUT_STEPS = ncm_pkg::DEF_MAX_GAMUT_STEPS,
	parameter int COLOR_FRAC_BITS = ncm_pkg::DEF_COLOR_FRAC_BITS
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   cfg_we,
	input  logic [ncm_pkg::CFG_IDX_W-1:0]          cfg_index,
	input  logic [ncm_pkg::CFG_DATA_W-1:0]         cfg_wdata,
	input  logic                                   sample_valid,
	output logic                                   sample_stall,
	input  logic signed [ncm_pkg::LUMA_W-1:0]      luma,
	input  logic signed [ncm_pkg::CHROMA_W-1:0]    chroma_i,
	input  logic signed [ncm_pkg::CHROMA_W-1:0]    chroma_q,
	input  logic [ncm_pkg::PHASE_W-1:0]            frame_phase,
	input  logic                                   line_odd,
	input  logic [ncm_pkg::PHASE_W-1:0]            sample_phase,
	output logic                                   result_valid,
	input  logic                                   result_stall,
	output logic signed [ncm_pkg::SAMPLE_W-1:0]    composite_sample,
	output logic [ncm_pkg::STEPS_W-1:0]            gamut_steps
);

	// Luma of exactly 1.0 in the chosen fixed point.
	localparam int ONE = 1 << COLOR_FRAC_BITS;

	// Configuration registers.
	logic signed [ncm_pkg::LEVEL_W-1:0] black_level_q;
	logic signed [ncm_pkg::LEVEL_W-1:0] white_level_q;
	logic signed [ncm_pkg::LEVEL_W-1:0] sync_level_q;
	logic [ncm_pkg::GAIN_W-1:0]         carrier_gain_q;

	// The pipeline moves as one unless a finished result is being held.
	logic adv;

	logic               valid_s0;
	ncm_pkg::ncm_item_t item_s0;
	ncm_pkg::ncm_item_t item_entry;

	logic               chain_valid [0:MAX_GAMUT_STEPS];
	ncm_pkg::ncm_item_t chain_item  [0:MAX_GAMUT_STEPS];

	assign adv          = !(result_valid && result_stall);
	assign sample_stall = !adv;

	// Register writes. Only legal while idle, so no interlock with the pipeline.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			black_level_q  <= ncm_pkg::RST_BLACK;
			white_level_q  <= ncm_pkg::RST_WHITE;
			sync_level_q   <= ncm_pkg::RST_SYNC;
			carrier_gain_q <= ncm_pkg::RST_GAIN;
		end else if (cfg_we) begin
			unique case (cfg_index)
				ncm_pkg::CFG_BLACK: black_level_q  <= $signed(cfg_wdata);
				ncm_pkg::CFG_WHITE: white_level_q  <= $signed(cfg_wdata);
				ncm_pkg::CFG_SYNC:  sync_level_q   <= $signed(cfg_wdata);
				ncm_pkg::CFG_GAIN:  carrier_gain_q <= cfg_wdata[ncm_pkg::GAIN_W-1:0];
				default: ;
			endcase
		end
	end

	// Entry stage: luma is clamped to the range 0 to 1.0, and the subcarrier
	// phase is folded from frame, line parity and sample position.
	always_comb begin
		item_entry       = '0;
		item_entry.ci    = chroma_i;
		item_entry.cq    = chroma_q;
		item_entry.phase = frame_phase + {line_odd, 1'b0} + sample_phase;
		if (luma[ncm_pkg::LUMA_W-1]) begin
			item_entry.y = '0;
		end else if (int'(luma) > ONE) begin
			item_entry.y = ncm_pkg::Y_W'(ONE);
		end else begin
			item_entry.y = luma[ncm_pkg::Y_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s0 <= 1'b0;
		end else if (adv) begin
			valid_s0 <= sample_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			item_s0 <= item_entry;
		end
	end

	assign chain_valid[0] = valid_s0;
	assign chain_item[0]  = item_s0;

	// Each cell may apply one 0.9 scaling; once a sample is found inside the
	// gamut it is marked done and the remaining cells pass it through untouched.
	for (genvar k = 0; k < MAX_GAMUT_STEPS; k++) begin : g_cell
		ncm_gamut_cell #(
			.COLOR_FRAC_BITS(COLOR_FRAC_BITS)
		) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.adv      (adv),
			.valid_in (chain_valid[k]),
			.item_in  (chain_item[k]),
			.valid_out(chain_valid[k+1]),
			.item_out (chain_item[k+1])
		);
	end

	ncm_level #(
		.COLOR_FRAC_BITS(COLOR_FRAC_BITS)
	) u_level (
		.clk         (clk),
		.arst_n      (arst_n),
		.adv         (adv),
		.valid_in    (chain_valid[MAX_GAMUT_STEPS]),
		.item_in     (chain_item[MAX_GAMUT_STEPS]),
		.black_level (black_level_q),
		.white_level (white_level_q),
		.sync_level  (sync_level_q),
		.carrier_gain(carrier_gain_q),
		.valid_out   (result_valid),
		.composite   (composite_sample),
		.steps       (gamut_steps)
	);

	// The chain can never count more scalings than it has cells.
	a_steps_bound: assert property (@(posedge clk) disable iff (!arst_n)
		chain_valid[MAX_GAMUT_STEPS] |->
			(int'(chain_item[MAX_GAMUT_STEPS].steps) <= MAX_GAMUT_STEPS))
		else $error("gamut step count exceeds the number of cells");

	// A sample that left the chain with scalings to spare must have met the gamut.
	a_done_early: assert property (@(posedge clk) disable iff (!arst_n)
		(chain_valid[MAX_GAMUT_STEPS] &&
		 (int'(chain_item[MAX_GAMUT_STEPS].steps) < MAX_GAMUT_STEPS)) |->
			chain_item[MAX_GAMUT_STEPS].done)
		else $error("sample stopped scaling without reaching the gamut");

	// The output floor holds whatever the sync level is set to.
	a_out_floor: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> (int'(composite_sample) >= ncm_pkg::OUT_MIN))
		else $error("composite sample below the lowest allowed level");

endmodule

FILE: dv/ntsc_chroma_modulator_tb.sv
// Self-checking testbench of the NTSC chroma modulator with a scoreboard and random stimulus.
`timescale 1ns / 100ps

module ntsc_chroma_modulator_tb;

	// Timing of the run. The tail at the end outlasts PIPE_LATENCY, the
	// pipeline depth of the design.
	localparam int PIPE_LATENCY  = 2 * ncm_pkg::DEF_MAX_GAMUT_STEPS + 4;
	localparam int TAIL_CYCLES   = 2 * PIPE_LATENCY;
	localparam int STALL_LIMIT   = 3000;
	localparam int LONG_HOLD     = 300;
	localparam int SEG_ITEMS     = 255;
	localparam int NUM_SEGS      = 6;

	// Fixed-point view of the colour path, apart from the design files but for the fraction width.
	localparam int     FRAC_BITS  = ncm_pkg::DEF_COLOR_FRAC_BITS;
	localparam longint UNIT_ONE   = longint'(1) << FRAC_BITS;
	localparam longint RGB_SCALE  = 10000;
	localparam longint CLIP_IRE   = 120 * 256;
	localparam longint FLOOR_IRE  = -80 * 256;
	localparam longint CEIL_IRE   = 140 * 256;
	localparam longint SAMPLE_TOP = 32767;

	typedef struct packed {
		logic signed [ncm_pkg::SAMPLE_W-1:0] composite;
		logic [ncm_pkg::STEPS_W-1:0]         steps;
	} level_t;

	// The scoreboard keeps its own copy of the level registers, works out the
	// composite level of every accepted sample and checks results in order.
	class composite_scoreboard;
		longint black, white, sync_lvl, gain;
		level_t expected_levels[$];
		int     fails;

		function new();
			black    = ncm_pkg::RST_BLACK;
			white    = ncm_pkg::RST_WHITE;
			sync_lvl = ncm_pkg::RST_SYNC;
			gain     = ncm_pkg::RST_GAIN;
			fails    = 0;
		endfunction

		function void set_register(logic [ncm_pkg::CFG_IDX_W-1:0] idx,
				logic [ncm_pkg::CFG_DATA_W-1:0] data);
			case (idx)
				ncm_pkg::CFG_BLACK: black    = $signed(data);
				ncm_pkg::CFG_WHITE: white    = $signed(data);
				ncm_pkg::CFG_SYNC:  sync_lvl = $signed(data);
				ncm_pkg::CFG_GAIN:  gain     = data[ncm_pkg::GAIN_W-1:0];
				default: ;
			endcase
		endfunction

		function int pending();
			return expected_levels.size();
		endfunction

		static function bit within_unit(longint v);
			return v >= 0 && v <= RGB_SCALE * UNIT_ONE;
		endfunction

		// I or Q times 0.9, rounded to nearest with ties away from zero.
		static function longint shrink_chroma(longint x);
			longint t;
			t = x * 9;
			if (t >= 0)
				return (t + 5) / 10;
			return -((-t + 5) / 10);
		endfunction

		function level_t composite_level(logic signed [ncm_pkg::LUMA_W-1:0] y_in,
				logic signed [ncm_pkg::CHROMA_W-1:0] ci_in,
				logic signed [ncm_pkg::CHROMA_W-1:0] cq_in,
				logic [ncm_pkg::PHASE_W-1:0] fp, logic lodd,
				logic [ncm_pkg::PHASE_W-1:0] sp);
			longint y, ci, cq, red, grn, blu, carried, lvl, whole, frac;
			int steps;
			logic [ncm_pkg::PHASE_W-1:0] phase;
			level_t lv;
			y = y_in;
			if (y < 0)
				y = 0;
			if (y > UNIT_ONE)
				y = UNIT_ONE;
			ci = ci_in;
			cq = cq_in;
			steps = 0;
			// Shrink chroma until all of R, G and B fall within 0..1 or the steps run out.
			while (steps < ncm_pkg::DEF_MAX_GAMUT_STEPS) begin
				red = y * RGB_SCALE + 9563 * ci + 6210 * cq;
				grn = y * RGB_SCALE - 2721 * ci - 6474 * cq;
				blu = y * RGB_SCALE - 11070 * ci + 17046 * cq;
				if (within_unit(red) && within_unit(grn) && within_unit(blu))
					break;
				ci = shrink_chroma(ci);
				cq = shrink_chroma(cq);
				steps++;
			end
			phase = fp + {lodd, 1'b0} + sp;
			case (phase)
				ncm_pkg::PH_I:     carried = ci;
				ncm_pkg::PH_Q:     carried = cq;
				ncm_pkg::PH_NEG_I: carried = -ci;
				default:           carried = -cq;
			endcase
			lvl = black * UNIT_ONE + y * (white - black) + gain * carried;
			// The white clip comes first, so a sync level above it wins.
			if (lvl > CLIP_IRE * UNIT_ONE)
				lvl = CLIP_IRE * UNIT_ONE;
			if (lvl < sync_lvl * UNIT_ONE)
				lvl = sync_lvl * UNIT_ONE;
			// Round to nearest, ties to even.
			whole = lvl >>> FRAC_BITS;
			frac  = lvl & (UNIT_ONE - 1);
			if (frac > UNIT_ONE / 2 || (frac == UNIT_ONE / 2 && whole[0]))
				whole++;
			if (whole < FLOOR_IRE)
				whole = FLOOR_IRE;
			if (whole > CEIL_IRE)
				whole = CEIL_IRE;
			if (whole > SAMPLE_TOP)
				whole = SAMPLE_TOP;
			lv.composite = whole[ncm_pkg::SAMPLE_W-1:0];
			lv.steps     = steps[ncm_pkg::STEPS_W-1:0];
			return lv;
		endfunction

		function void note_sample(logic signed [ncm_pkg::LUMA_W-1:0] y_in,
				logic signed [ncm_pkg::CHROMA_W-1:0] ci_in,
				logic signed [ncm_pkg::CHROMA_W-1:0] cq_in,
				logic [ncm_pkg::PHASE_W-1:0] fp, logic lodd,
				logic [ncm_pkg::PHASE_W-1:0] sp);
			expected_levels.push_back(composite_level(y_in, ci_in, cq_in, fp, lodd, sp));
		endfunction

		task report(string msg);
			$display("[%0t] mismatch: %s", $time, msg);
			fails++;
		endtask

		task check_result(logic signed [ncm_pkg::SAMPLE_W-1:0] got_level,
				logic [ncm_pkg::STEPS_W-1:0] got_steps);
			level_t want;
			if (expected_levels.size() == 0) begin
				report($sformatf("result %0d / %0d with no sample pending",
					got_level, got_steps));
				return;
			end
			want = expected_levels.pop_front();
			if (got_level !== want.composite)
				report($sformatf("composite_sample %0d, expected %0d",
					got_level, want.composite));
			if (got_steps !== want.steps)
				report($sformatf("gamut_steps %0d, expected %0d", got_steps, want.steps));
		endtask
	endclass

	logic                                 clk = 1'b0;
	logic                                 arst_n = 1'b0;
	logic                                 cfg_we = 1'b0;
	logic [ncm_pkg::CFG_IDX_W-1:0]        cfg_index = ncm_pkg::CFG_BLACK;
	logic [ncm_pkg::CFG_DATA_W-1:0]       cfg_wdata = '0;
	logic                                 sample_valid = 1'b0;
	logic                                 sample_stall;
	logic signed [ncm_pkg::LUMA_W-1:0]    luma = '0;
	logic signed [ncm_pkg::CHROMA_W-1:0]  chroma_i = '0;
	logic signed [ncm_pkg::CHROMA_W-1:0]  chroma_q = '0;
	logic [ncm_pkg::PHASE_W-1:0]          frame_phase = '0;
	logic                                 line_odd = 1'b0;
	logic [ncm_pkg::PHASE_W-1:0]          sample_phase = '0;
	logic                                 result_valid;
	logic                                 result_stall = 1'b0;
	logic signed [ncm_pkg::SAMPLE_W-1:0]  composite_sample;
	logic [ncm_pkg::STEPS_W-1:0]          gamut_steps;

	composite_scoreboard sb = new();

	// Percentages of cycles in which each side holds back, and the one-off
	// request for the receiver to sit on its stall for a long stretch.
	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	bit long_hold_req = 1'b0;

	ntsc_chroma_modulator i_dut (
		.clk              (clk),
		.arst_n           (arst_n),
		.cfg_we           (cfg_we),
		.cfg_index        (cfg_index),
		.cfg_wdata        (cfg_wdata),
		.sample_valid     (sample_valid),
		.sample_stall     (sample_stall),
		.luma             (luma),
		.chroma_i         (chroma_i),
		.chroma_q         (chroma_q),
		.frame_phase      (frame_phase),
		.line_odd         (line_odd),
		.sample_phase     (sample_phase),
		.result_valid     (result_valid),
		.result_stall     (result_stall),
		.composite_sample (composite_sample),
		.gamut_steps      (gamut_steps)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// Inputs only change at rising edges, so everything is settled by the
	// falling edge. A transfer is therefore decided by what is seen there.

	// Offers one sample, after a random number of idle cycles, and holds it
	// steady until the block takes it. Called and returning at a rising edge.
	task automatic offer(input logic signed [ncm_pkg::LUMA_W-1:0] y,
			input logic signed [ncm_pkg::CHROMA_W-1:0] ci,
			input logic signed [ncm_pkg::CHROMA_W-1:0] cq,
			input logic [ncm_pkg::PHASE_W-1:0] fp, input logic lodd,
			input logic [ncm_pkg::PHASE_W-1:0] sp);
		bit taken;
		taken = 1'b0;
		while ($urandom_range(99) < send_idle_pct) begin
			sample_valid <= 1'b0;
			@(posedge clk);
		end
		sample_valid <= 1'b1;
		luma         <= y;
		chroma_i     <= ci;
		chroma_q     <= cq;
		frame_phase  <= fp;
		line_odd     <= lodd;
		sample_phase <= sp;
		while (!taken) begin
			@(negedge clk);
			taken = !sample_stall;
			@(posedge clk);
		end
		sb.note_sample(y, ci, cq, fp, lodd, sp);
	endtask

	// Random sample. Luma is mostly inside the clamp range, chroma is shifted
	// down by a random amount so that every number of gamut steps turns up.
	task automatic offer_random();
		logic signed [ncm_pkg::LUMA_W-1:0]   y;
		logic signed [ncm_pkg::CHROMA_W-1:0] ci, cq;
		logic [31:0]                         rnd;
		rnd = $urandom;
		case ($urandom_range(0, 5))
			0, 1, 2: y = ncm_pkg::LUMA_W'($urandom_range(0, 4096));
			3:       y = ncm_pkg::LUMA_W'($urandom);
			4:       y = ncm_pkg::LUMA_W'($urandom_range(4090, 4100));
			default: begin
				case ($urandom_range(0, 3))
					0:       y = -14'sd8192;
					1:       y = 14'sd8191;
					2:       y = 14'sd0;
					default: y = -14'sd1;
				endcase
			end
		endcase
		ci = ncm_pkg::CHROMA_W'($urandom);
		cq = ncm_pkg::CHROMA_W'($urandom);
		ci = ci >>> $urandom_range(0, 7);
		cq = cq >>> $urandom_range(0, 7);
		offer(y, ci, cq, rnd[1:0], rnd[2], rnd[4:3]);
	endtask

	// Lowers valid and waits, with at least one edge, until every result
	// that is owed has come back.
	task automatic wait_drained();
		sample_valid <= 1'b0;
		do
			@(posedge clk);
		while (sb.pending() != 0);
	endtask

	// Writes the four level registers on consecutive edges. Only used while
	// the pipeline is empty.
	task automatic write_levels(input logic [ncm_pkg::CFG_DATA_W-1:0] blk,
			input logic [ncm_pkg::CFG_DATA_W-1:0] wht,
			input logic [ncm_pkg::CFG_DATA_W-1:0] syn,
			input logic [ncm_pkg::CFG_DATA_W-1:0] gn);
		cfg_we    <= 1'b1;
		cfg_index <= ncm_pkg::CFG_BLACK;
		cfg_wdata <= blk;
		@(posedge clk);
		cfg_index <= ncm_pkg::CFG_WHITE;
		cfg_wdata <= wht;
		@(posedge clk);
		cfg_index <= ncm_pkg::CFG_SYNC;
		cfg_wdata <= syn;
		@(posedge clk);
		cfg_index <= ncm_pkg::CFG_GAIN;
		cfg_wdata <= gn;
		@(posedge clk);
		cfg_we <= 1'b0;
		sb.set_register(ncm_pkg::CFG_BLACK, blk);
		sb.set_register(ncm_pkg::CFG_WHITE, wht);
		sb.set_register(ncm_pkg::CFG_SYNC, syn);
		sb.set_register(ncm_pkg::CFG_GAIN, gn);
	endtask

	function automatic logic [ncm_pkg::CFG_DATA_W-1:0] random_level();
		int v;
		v = int'($urandom_range(0, 56320)) - 20480;
		return ncm_pkg::CFG_DATA_W'(v);
	endfunction

	// Result side: decides the stall for each cycle, honours the long hold
	// once it is asked for, and checks every result transfer.
	initial begin : result_sink
		int hold_left;
		bit hold_done;
		bit stall_now;
		hold_left = 0;
		hold_done = 1'b0;
		forever begin
			@(posedge clk);
			if (long_hold_req && !hold_done) begin
				hold_done = 1'b1;
				hold_left = LONG_HOLD;
			end
			if (hold_left > 0) begin
				stall_now = 1'b1;
				hold_left--;
			end else begin
				stall_now = $urandom_range(99) < recv_idle_pct;
			end
			result_stall <= stall_now;
			@(negedge clk);
			if (result_valid && !result_stall)
				sb.check_result(composite_sample, gamut_steps);
		end
	end

	// Watchdog: the run is cut short once too many cycles pass without any
	// transfer on either channel.
	initial begin : watchdog
		int quiet_cycles;
		quiet_cycles = 0;
		while (quiet_cycles < STALL_LIMIT) begin
			@(negedge clk);
			if ((sample_valid && !sample_stall) || (result_valid && !result_stall))
				quiet_cycles = 0;
			else
				quiet_cycles++;
		end
		$display("** ntsc_chroma_modulator: FAILED **");
		$finish;
	end

	initial begin : stimulus
		int seg;
		int n;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed samples at the reset levels, back to back.
		offer(14'sd0, 14'sd0, 14'sd0, 2'd0, 1'b0, 2'd0);
		offer(14'sd4096, 14'sd0, 14'sd0, 2'd1, 1'b0, 2'd0);
		// Luma far outside the range is clamped to black and to white.
		offer(-14'sd8192, 14'sd0, 14'sd0, 2'd2, 1'b1, 2'd3);
		offer(14'sd8191, 14'sd0, 14'sd0, 2'd3, 1'b1, 2'd1);
		// Luma of 16 lands on an exact half just above an even level, 48 just
		// above an odd one.
		offer(14'sd16, 14'sd0, 14'sd0, 2'd0, 1'b0, 2'd0);
		offer(14'sd48, 14'sd0, 14'sd0, 2'd0, 1'b0, 2'd0);
		// Chroma extremes, which need the gamut chain.
		offer(14'sd2048, 14'sd8191, 14'sd0, 2'd0, 1'b0, 2'd0);
		offer(14'sd2048, -14'sd8192, 14'sd0, 2'd0, 1'b0, 2'd1);
		offer(14'sd2048, 14'sd0, 14'sd8191, 2'd0, 1'b1, 2'd0);
		offer(14'sd2048, 14'sd0, -14'sd8192, 2'd1, 1'b1, 2'd1);
		// These run out of scaling steps before reaching the gamut.
		offer(14'sd0, -14'sd8192, 14'sd8191, 2'd2, 1'b0, 2'd2);
		offer(14'sd4096, 14'sd8191, -14'sd8192, 2'd3, 1'b1, 2'd0);
		offer(14'sd8191, 14'sd8191, 14'sd8191, 2'd3, 1'b1, 2'd3);
		// Each quadrature phase with a moderate in-gamut colour.
		offer(14'sd2048, 14'sd400, 14'sd300, 2'd0, 1'b0, 2'd0);
		offer(14'sd2048, 14'sd400, 14'sd300, 2'd0, 1'b0, 2'd1);
		offer(14'sd2048, 14'sd400, 14'sd300, 2'd0, 1'b0, 2'd2);
		offer(14'sd2048, 14'sd400, 14'sd300, 2'd0, 1'b0, 2'd3);
		offer(14'sd2048, 14'sd400, 14'sd300, 2'd1, 1'b1, 2'd2);
		offer(-14'sd1, -14'sd1, -14'sd1, 2'd1, 1'b0, 2'd2);
		offer(14'sd4095, 14'sd100, -14'sd100, 2'd0, 1'b0, 2'd3);
		offer(14'sd4097, -14'sd100, 14'sd100, 2'd2, 1'b1, 2'd1);
		wait_drained();

		// White below black and a sync level above the white clip, which
		// then sets every output; zero gain.
		write_levels(17'sd35840, -17'sd20480, 17'sd35840, 17'd0);
		offer(14'sd0, 14'sd0, 14'sd0, 2'd0, 1'b0, 2'd0);
		offer(14'sd4096, 14'sd8191, 14'sd0, 2'd0, 1'b0, 2'd0);
		offer(14'sd2048, 14'sd300, -14'sd200, 2'd3, 1'b1, 2'd2);
		wait_drained();

		// Random segments: the first pair with the sender idling less than
		// the receiver, the second pair the other way round, the last pair
		// with no idling at all.
		for (seg = 0; seg < NUM_SEGS; seg++) begin
			case (seg / 2)
				0: begin
					send_idle_pct = 32;
					recv_idle_pct = 55;
				end
				1: begin
					send_idle_pct = 55;
					recv_idle_pct = 32;
				end
				default: begin
					send_idle_pct = 0;
					recv_idle_pct = 0;
				end
			endcase
			case (seg)
				0: write_levels(17'sd1920, 17'sd25600, -17'sd10240, 17'd5120);
				1: write_levels(-17'sd20480, 17'sd35840, -17'sd20480, 17'd65535);
				2: write_levels(random_level(), random_level(), random_level(),
					ncm_pkg::CFG_DATA_W'($urandom_range(0, 65535)));
				3: write_levels(17'sd35840, -17'sd20480, -17'sd20480, 17'd12000);
				// The full width of the registers; the gain write has its
				// unused top bit set.
				4: write_levels(17'h10000, 17'h0FFFF, 17'h10000, 17'h1FFFF);
				default: write_levels(random_level(), random_level(), random_level(),
					ncm_pkg::CFG_DATA_W'($urandom_range(0, 65535)));
			endcase
			// The receiver sits on its stall while samples keep coming, so
			// the pipeline fills and the sample side has to stall too.
			if (seg == 2)
				long_hold_req = 1'b1;
			for (n = 0; n < SEG_ITEMS; n++) begin
				// A pause on the sample side until the pipeline is empty.
				if (seg == 4 && n == 120)
					wait_drained();
				offer_random();
			end
			wait_drained();
		end

		repeat (TAIL_CYCLES) @(posedge clk);
		if (sb.fails == 0 && sb.pending() == 0)
			$display("** ntsc_chroma_modulator: PASSED **");
		else
			$display("** ntsc_chroma_modulator: FAILED **");
		$finish;
	end

endmodule

FILE: files.f
hw/rtl/ncm_pkg.sv
hw/rtl/ncm_gamut_cell.sv
hw/rtl/ncm_level.sv
hw/rtl/ntsc_chroma_modulator.sv
dv/ntsc_chroma_modulator_tb.sv
